>>> design/vpss_pkg.sv
package vpss_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int WIDE_W = 66;

   localparam int MAX_POINTS_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_WRITTEN = 2'd0;
   localparam logic [1:0] STAT_RUN     = 2'd1;
   localparam logic [1:0] STAT_READ    = 2'd2;
   localparam logic [1:0] STAT_RANGE   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_N_POINTS   = 3'd0;
   localparam logic [2:0] REG_N_STEPS    = 3'd1;
   localparam logic [2:0] REG_MAX_ITER   = 3'd2;
   localparam logic [2:0] REG_TOLERANCE  = 3'd3;
   localparam logic [2:0] REG_DIFFUSION  = 3'd4;
   localparam logic [2:0] REG_ADVECTION  = 3'd5;
   localparam logic [2:0] REG_SOURCE     = 3'd6;
   localparam logic [2:0] REG_CORRECTION = 3'd7;

   // register reset values
   localparam logic [8:0]  RST_N_POINTS  = 9'd64;
   localparam logic [15:0] RST_N_STEPS   = 16'd100;
   localparam logic [15:0] RST_MAX_ITER  = 16'd100;
   localparam logic [30:0] RST_TOLERANCE = 31'd7;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_VL0,
      S_VL0W,
      S_VL1W,
      S_VRD,
      S_VM1,
      S_VM2,
      S_VM3,
      S_VM4,
      S_SW0,
      S_SW0W,
      S_SW1W,
      S_SRD,
      S_SM1,
      S_SM2,
      S_SM3,
      S_SM4,
      S_SE0,
      S_SE1,
      S_SE2,
      S_C0,
      S_C0W,
      S_CRD,
      S_CM1,
      S_CM2,
      S_CM3,
      S_CE0,
      S_CE1
   } state_type;

   localparam logic signed [WIDE_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -66'sd2147483648;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] absdiff(input logic signed [DATA_W-1:0] a,
                                                 input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] d;
      d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
      if (d < 0) begin
         d = -d;
      end
      return d[DATA_W-1:0];
   endfunction

endpackage

>>> design/vpss_ram.sv
module vpss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/vpss_mul.sv
module vpss_mul #(
   parameter int FRAC_BITS = vpss_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic signed [vpss_pkg::DATA_W-1:0] coef,
   input  logic signed [vpss_pkg::DATA_W-1:0] operand,
   output logic signed [vpss_pkg::PROD_W-1:0] result
);

   localparam logic signed [vpss_pkg::PROD_W-1:0] ROUND =
      vpss_pkg::PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

   logic signed [vpss_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= vpss_pkg::PROD_W'(coef) * vpss_pkg::PROD_W'(operand);
   end

   // round to nearest, ties up, then floor shift
   assign result = (prod_ff + ROUND) >>> FRAC_BITS;

endmodule

>>> design/velocity_pressure_stencil_solver.sv
// 1-D velocity / pressure stencil solver, signed fixed point.
// Requests enter on req_* (mode, node_index, sample_value); one response per
// request leaves on rsp_* (velocity_out, pressure_out, status). Registers are
// written on csr_*; the user must write them only while the block is idle,
// which the block does not enforce; csr_ready is always high. Write,
// out-of-range and unknown-mode requests answer the cycle after acceptance;
// a read answers from S_READ, after the memory read register. A run request
// holds the sequencer for n_steps time steps, each running the velocity
// update, the pressure sweeps and the correction and end nodes in turn, with
// one shared multiplier and a single read port on each grid memory.
// Both grids live in two synchronous memories (velocity with ghost node,
// pressure); every node update reads, computes and writes back in order.
// After reset the block runs a clearing pass that zeroes both memories;
// req_tready stays low until it ends.
// The response sits in an output register; while the receiver stalls a new
// request is only taken once that register is being emptied.
module velocity_pressure_stencil_solver #(
   parameter int MAX_POINTS = vpss_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = vpss_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // mode[1:0], node_index[10:2], sample_value[42:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // velocity_out[31:0], pressure_out[63:32], status[65:64]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int DW = vpss_pkg::DATA_W;
   localparam int WW = vpss_pkg::WIDE_W;
   localparam int AW = $clog2(MAX_POINTS + 1);
   localparam int PW = $clog2(MAX_POINTS);
   localparam int CW = (AW > 9) ? AW : 9;
   localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   // configuration
   logic [8:0]           cfg_npts_ff;
   logic [15:0]          cfg_steps_ff;
   logic [15:0]          cfg_iter_ff;
   logic [30:0]          cfg_tol_ff;
   logic signed [DW-1:0] cfg_diff_ff;
   logic signed [DW-1:0] cfg_adv_ff;
   logic signed [DW-1:0] cfg_src_ff;
   logic signed [DW-1:0] cfg_corr_ff;

   vpss_pkg::state_type state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [15:0]          step_ff, step_in;
   logic [15:0]          sweep_ff, sweep_in;
   logic [DW-1:0]        err_ff, err_in;
   logic signed [DW-1:0] ul_ff, ul_in, uc_ff, uc_in, ur_ff, ur_in;
   logic signed [DW-1:0] pl_ff, pl_in, pc_ff, pc_in, pr_ff, pr_in;
   logic signed [DW-1:0] p1new_ff, p1new_in, end0_ff, end0_in, end1_ff, end1_in;
   logic signed [DW-1:0] opa_ff, opa_in, opb_ff, opb_in, nv_ff, nv_in;
   logic signed [DW:0]   half_ff, half_in;
   logic signed [vpss_pkg::PROD_W-1:0] q1_ff, q1_in;
   logic                 ghost_ff, ghost_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_vel_ff, rsp_vel_in, rsp_prs_ff, rsp_prs_in;
   logic [1:0]           rsp_stat_ff, rsp_stat_in;
   logic                 out_load;

   // memory ports
   logic          v_we, v_re, p_we, p_re;
   logic [AW-1:0] v_waddr, v_raddr;
   logic [PW-1:0] p_waddr, p_raddr;
   logic [DW-1:0] v_wdata, v_rdata, p_wdata, p_rdata;
   logic signed [DW-1:0] vrd, prd;

   logic signed [DW-1:0] mul_coef, mul_opnd;
   logic signed [vpss_pkg::PROD_W-1:0] mul_res;

   // request fields
   logic [1:0]           req_mode;
   logic [8:0]           req_idx;
   logic signed [DW-1:0] req_sample;
   logic                 req_take, in_range;
   logic [CW-1:0]        n_ext, n_cw;
   logic [AW-1:0]        n_act, nm1, nm2, ip1, req_addr;

   assign req_mode   = req_tdata[1:0];
   assign req_idx    = req_tdata[10:2];
   assign req_sample = req_tdata[42:11];

   assign n_ext = CW'(cfg_npts_ff);
   assign n_cw  = (n_ext < CW'(3)) ? CW'(3) :
                  (n_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : n_ext;
   assign n_act = n_cw[AW-1:0];
   assign nm1   = n_act - AW'(1);
   assign nm2   = n_act - AW'(2);
   assign ip1   = idx_ff + AW'(1);

   assign in_range = CW'(req_idx) <= n_cw;
   assign req_addr = in_range ? AW'(CW'(req_idx)) : '0;

   assign req_tready = (state_ff == vpss_pkg::S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign vrd = v_rdata;
   assign prd = p_rdata;

   vpss_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS + 1)) u_vel_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v_re),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   vpss_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_prs_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   vpss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .coef    (mul_coef),
      .operand (mul_opnd),
      .result  (mul_res)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_npts_ff  <= vpss_pkg::RST_N_POINTS;
         cfg_steps_ff <= vpss_pkg::RST_N_STEPS;
         cfg_iter_ff  <= vpss_pkg::RST_MAX_ITER;
         cfg_tol_ff   <= vpss_pkg::RST_TOLERANCE;
         cfg_diff_ff  <= '0;
         cfg_adv_ff   <= '0;
         cfg_src_ff   <= '0;
         cfg_corr_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            vpss_pkg::REG_N_POINTS:   cfg_npts_ff  <= csr_data[8:0];
            vpss_pkg::REG_N_STEPS:    cfg_steps_ff <= csr_data[15:0];
            vpss_pkg::REG_MAX_ITER:   cfg_iter_ff  <= csr_data[15:0];
            vpss_pkg::REG_TOLERANCE:  cfg_tol_ff   <= csr_data[30:0];
            vpss_pkg::REG_DIFFUSION:  cfg_diff_ff  <= csr_data;
            vpss_pkg::REG_ADVECTION:  cfg_adv_ff   <= csr_data;
            vpss_pkg::REG_SOURCE:     cfg_src_ff   <= csr_data;
            vpss_pkg::REG_CORRECTION: cfg_corr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer: next state, memory ports and datapath
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      sweep_in     = sweep_ff;
      err_in       = err_ff;
      ul_in        = ul_ff;
      uc_in        = uc_ff;
      ur_in        = ur_ff;
      pl_in        = pl_ff;
      pc_in        = pc_ff;
      pr_in        = pr_ff;
      p1new_in     = p1new_ff;
      end0_in      = end0_ff;
      end1_in      = end1_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      nv_in        = nv_ff;
      half_in      = half_ff;
      q1_in        = q1_ff;
      ghost_in     = ghost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_vel_in   = rsp_vel_ff;
      rsp_prs_in   = rsp_prs_ff;
      rsp_stat_in  = rsp_stat_ff;
      out_load     = 1'b0;
      v_we         = 1'b0;
      v_waddr      = idx_ff;
      v_wdata      = '0;
      v_re         = 1'b0;
      v_raddr      = idx_ff;
      p_we         = 1'b0;
      p_waddr      = idx_ff[PW-1:0];
      p_wdata      = '0;
      p_re         = 1'b0;
      p_raddr      = ip1[PW-1:0];
      mul_coef     = cfg_diff_ff;
      mul_opnd     = opa_ff;

      case (state_ff)
         vpss_pkg::S_CLEAR: begin
            // zero both grids, one node a cycle
            v_we    = 1'b1;
            v_waddr = clr_ff;
            p_we    = clr_ff < AW'(MAX_POINTS);
            p_waddr = clr_ff[PW-1:0];
            if (clr_ff == AW'(MAX_POINTS)) begin
               state_in = vpss_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         vpss_pkg::S_IDLE: begin
            if (req_take) begin
               rsp_vel_in  = '0;
               rsp_prs_in  = '0;
               rsp_stat_in = vpss_pkg::STAT_RANGE;
               case (req_mode)
                  vpss_pkg::MODE_WRITE: begin
                     out_load     = 1'b1;
                     rsp_valid_in = 1'b1;
                     if (in_range) begin
                        v_we        = 1'b1;
                        v_waddr     = req_addr;
                        v_wdata     = req_sample;
                        rsp_stat_in = vpss_pkg::STAT_WRITTEN;
                     end
                  end
                  vpss_pkg::MODE_RUN: begin
                     step_in = '0;
                     if (cfg_steps_ff == '0) begin
                        out_load     = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_stat_in  = vpss_pkg::STAT_RUN;
                     end else begin
                        state_in = vpss_pkg::S_VL0;
                     end
                  end
                  vpss_pkg::MODE_READ: begin
                     if (in_range) begin
                        v_re     = 1'b1;
                        v_raddr  = req_addr;
                        p_re     = 1'b1;
                        p_raddr  = req_addr[PW-1:0];
                        ghost_in = req_addr == n_act;
                        state_in = vpss_pkg::S_READ;
                     end else begin
                        out_load     = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     out_load     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         vpss_pkg::S_READ: begin
            out_load     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_vel_in   = vrd;
            rsp_prs_in   = ghost_ff ? '0 : prd;
            rsp_stat_in  = vpss_pkg::STAT_READ;
            state_in     = vpss_pkg::S_IDLE;
         end

         // velocity update: rolling window of old nodes
         vpss_pkg::S_VL0: begin
            v_re     = 1'b1;
            v_raddr  = '0;
            state_in = vpss_pkg::S_VL0W;
         end
         vpss_pkg::S_VL0W: begin
            ul_in    = vrd;
            v_re     = 1'b1;
            v_raddr  = AW'(1);
            state_in = vpss_pkg::S_VL1W;
         end
         vpss_pkg::S_VL1W: begin
            uc_in    = vrd;
            idx_in   = AW'(1);
            state_in = vpss_pkg::S_VRD;
         end
         vpss_pkg::S_VRD: begin
            v_re     = 1'b1;
            v_raddr  = ip1;
            state_in = vpss_pkg::S_VM1;
         end
         vpss_pkg::S_VM1: begin
            ur_in    = vrd;
            opa_in   = vpss_pkg::sat32(WW'(vrd) - WW'(uc_ff) - WW'(uc_ff) + WW'(ul_ff));
            opb_in   = vpss_pkg::sat32(WW'(uc_ff) - WW'(ul_ff));
            state_in = vpss_pkg::S_VM2;
         end
         vpss_pkg::S_VM2: begin
            mul_coef = cfg_diff_ff;
            mul_opnd = opa_ff;
            state_in = vpss_pkg::S_VM3;
         end
         vpss_pkg::S_VM3: begin
            q1_in    = mul_res;
            mul_coef = cfg_adv_ff;
            mul_opnd = opb_ff;
            state_in = vpss_pkg::S_VM4;
         end
         vpss_pkg::S_VM4: begin
            v_we    = 1'b1;
            v_waddr = idx_ff;
            v_wdata = vpss_pkg::sat32(WW'(uc_ff) + WW'(q1_ff) - WW'(mul_res));
            ul_in   = uc_ff;
            uc_in   = ur_ff;
            if (idx_ff == nm1) begin
               sweep_in = '0;
               state_in = (cfg_iter_ff == '0) ? vpss_pkg::S_C0 : vpss_pkg::S_SW0;
            end else begin
               idx_in   = ip1;
               state_in = vpss_pkg::S_VRD;
            end
         end

         // pressure sweep, in place
         vpss_pkg::S_SW0: begin
            p_re     = 1'b1;
            p_raddr  = '0;
            v_re     = 1'b1;
            v_raddr  = '0;
            state_in = vpss_pkg::S_SW0W;
         end
         vpss_pkg::S_SW0W: begin
            pl_in    = prd;
            end0_in  = prd;
            ul_in    = vrd;
            p_re     = 1'b1;
            p_raddr  = PW'(1);
            v_re     = 1'b1;
            v_raddr  = AW'(1);
            state_in = vpss_pkg::S_SW1W;
         end
         vpss_pkg::S_SW1W: begin
            pc_in    = prd;
            uc_in    = vrd;
            idx_in   = AW'(1);
            err_in   = '0;
            state_in = vpss_pkg::S_SRD;
         end
         vpss_pkg::S_SRD: begin
            p_re     = 1'b1;
            p_raddr  = ip1[PW-1:0];
            v_re     = 1'b1;
            v_raddr  = ip1;
            state_in = vpss_pkg::S_SM1;
         end
         vpss_pkg::S_SM1: begin
            pr_in    = prd;
            ur_in    = vrd;
            opa_in   = vpss_pkg::sat32(WW'(vrd) - WW'(ul_ff));
            half_in  = (DW+1)'((WW'(prd) + WW'(pl_ff) + WW'(1)) >>> 1);
            if (idx_ff == nm2) begin
               end1_in = prd;
            end
            state_in = vpss_pkg::S_SM2;
         end
         vpss_pkg::S_SM2: begin
            mul_coef = cfg_src_ff;
            mul_opnd = opa_ff;
            state_in = vpss_pkg::S_SM3;
         end
         vpss_pkg::S_SM3: begin
            nv_in    = vpss_pkg::sat32(WW'(half_ff) - WW'(mul_res));
            state_in = vpss_pkg::S_SM4;
         end
         vpss_pkg::S_SM4: begin
            p_we    = 1'b1;
            p_waddr = idx_ff[PW-1:0];
            p_wdata = nv_ff;
            if (vpss_pkg::absdiff(pc_ff, nv_ff) > err_ff) begin
               err_in = vpss_pkg::absdiff(pc_ff, nv_ff);
            end
            if (idx_ff == AW'(1)) begin
               p1new_in = nv_ff;
            end
            pl_in = nv_ff;
            pc_in = pr_ff;
            ul_in = uc_ff;
            uc_in = ur_ff;
            if (idx_ff == nm2) begin
               state_in = vpss_pkg::S_SE0;
            end else begin
               idx_in   = ip1;
               state_in = vpss_pkg::S_SRD;
            end
         end
         vpss_pkg::S_SE0: begin
            // periodic ends: node 0 takes node n-2
            p_we    = 1'b1;
            p_waddr = '0;
            p_wdata = pl_ff;
            if (vpss_pkg::absdiff(end0_ff, pl_ff) > err_ff) begin
               err_in = vpss_pkg::absdiff(end0_ff, pl_ff);
            end
            state_in = vpss_pkg::S_SE1;
         end
         vpss_pkg::S_SE1: begin
            // node n-1 takes node 1
            p_we    = 1'b1;
            p_waddr = nm1[PW-1:0];
            p_wdata = p1new_ff;
            if (vpss_pkg::absdiff(end1_ff, p1new_ff) > err_ff) begin
               err_in = vpss_pkg::absdiff(end1_ff, p1new_ff);
            end
            state_in = vpss_pkg::S_SE2;
         end
         vpss_pkg::S_SE2: begin
            if ((err_ff < {1'b0, cfg_tol_ff}) || (sweep_ff + 16'd1 == cfg_iter_ff)) begin
               state_in = vpss_pkg::S_C0;
            end else begin
               sweep_in = sweep_ff + 16'd1;
               state_in = vpss_pkg::S_SW0;
            end
         end

         // pressure correction
         vpss_pkg::S_C0: begin
            p_re     = 1'b1;
            p_raddr  = PW'(1);
            state_in = vpss_pkg::S_C0W;
         end
         vpss_pkg::S_C0W: begin
            pc_in    = prd;
            idx_in   = AW'(1);
            state_in = vpss_pkg::S_CRD;
         end
         vpss_pkg::S_CRD: begin
            p_re     = 1'b1;
            p_raddr  = ip1[PW-1:0];
            v_re     = 1'b1;
            v_raddr  = idx_ff;
            state_in = vpss_pkg::S_CM1;
         end
         vpss_pkg::S_CM1: begin
            pr_in    = prd;
            uc_in    = vrd;
            opa_in   = vpss_pkg::sat32(WW'(prd) - WW'(pc_ff));
            state_in = vpss_pkg::S_CM2;
         end
         vpss_pkg::S_CM2: begin
            mul_coef = cfg_corr_ff;
            mul_opnd = opa_ff;
            state_in = vpss_pkg::S_CM3;
         end
         vpss_pkg::S_CM3: begin
            v_we    = 1'b1;
            v_waddr = idx_ff;
            v_wdata = vpss_pkg::sat32(WW'(uc_ff) - WW'(mul_res));
            pc_in   = pr_ff;
            if (idx_ff == nm2) begin
               state_in = vpss_pkg::S_CE0;
            end else begin
               idx_in   = ip1;
               state_in = vpss_pkg::S_CRD;
            end
         end
         vpss_pkg::S_CE0: begin
            v_we     = 1'b1;
            v_waddr  = '0;
            v_wdata  = ONE;
            state_in = vpss_pkg::S_CE1;
         end
         vpss_pkg::S_CE1: begin
            v_we    = 1'b1;
            v_waddr = nm1;
            v_wdata = ONE;
            if (step_ff + 16'd1 == cfg_steps_ff) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_vel_in   = '0;
               rsp_prs_in   = '0;
               rsp_stat_in  = vpss_pkg::STAT_RUN;
               state_in     = vpss_pkg::S_IDLE;
            end else begin
               step_in  = step_ff + 16'd1;
               state_in = vpss_pkg::S_VL0;
            end
         end
         default: begin
            state_in = vpss_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpss_pkg::S_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         sweep_ff     <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         sweep_ff     <= sweep_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      ul_ff       <= ul_in;
      uc_ff       <= uc_in;
      ur_ff       <= ur_in;
      pl_ff       <= pl_in;
      pc_ff       <= pc_in;
      pr_ff       <= pr_in;
      p1new_ff    <= p1new_in;
      end0_ff     <= end0_in;
      end1_ff     <= end1_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      nv_ff       <= nv_in;
      half_ff     <= half_in;
      q1_ff       <= q1_in;
      ghost_ff    <= ghost_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_prs_ff  <= rsp_prs_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_stat_ff, rsp_prs_ff, rsp_vel_ff};

   // the sequencer never takes a request while busy
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == vpss_pkg::S_IDLE))
      else $error("request taken while sequencer busy");

   // a response is only loaded into a free or draining output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten");

   // pressure updates stay on interior nodes
   a_sweep_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vpss_pkg::S_SM4) |-> (idx_ff >= AW'(1) && idx_ff <= nm2))
      else $error("sweep index out of interior");

   // sweep counter stays below the cap
   a_sweep_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vpss_pkg::S_SE2) |-> (sweep_ff < cfg_iter_ff))
      else $error("sweep count beyond cap");

endmodule
